// ----- src/met_pkg.sv -----
// Shared widths, constants and types for the escape-time pixel block.
package met_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 28;

    localparam int C_W    = 32;
    localparam int STEP_W = 29;
    localparam int ITER_W = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_REAL_ORIGIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_ORIGIN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COORD_STEP  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = CFG_IDX_W'(3);

    localparam logic [C_W-1:0]    RST_REAL_ORIGIN = 32'hE000_0000;
    localparam logic [C_W-1:0]    RST_IMAG_ORIGIN = 32'hE000_0000;
    localparam logic [STEP_W-1:0] RST_COORD_STEP  = STEP_W'(1677722);
    localparam logic [ITER_W-1:0] RST_MAX_ITER    = ITER_W'(255);

    localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * COORD_BITS + ITER_W + 7) / 8) * 8;

    // Magnitude of z after the bound test is at most 2.0, so it needs FRAC_BITS+2 bits.
    localparam int MW = (FRAC_BITS + 2 > STEP_W) ? FRAC_BITS + 2 : STEP_W;
    localparam int PW = 2 * MW;

    // Truncated square is at most 4.0; cross term is at most 8.0.
    localparam int SQW = FRAC_BITS + 3;
    localparam int CRW = FRAC_BITS + 4;
    localparam int ZW  = (FRAC_BITS + 5 > C_W + 2) ? FRAC_BITS + 5 : C_W + 2;

    // Width of origin plus coordinate times step before saturation.
    localparam int CSUM_W = (COORD_BITS + STEP_W + 2 > C_W + 1) ?
                            COORD_BITS + STEP_W + 2 : C_W + 1;

    localparam logic [SQW:0] SQ_FOUR = (SQW + 1)'(1) << (FRAC_BITS + 2);
    localparam logic signed [ZW-1:0] Z_TWO     = ZW'(1) << (FRAC_BITS + 1);
    localparam logic signed [ZW-1:0] Z_NEG_TWO = -(ZW'(1) << (FRAC_BITS + 1));

    localparam logic signed [CSUM_W-1:0] C_MAX =
        {{(CSUM_W - C_W + 1){1'b0}}, {(C_W - 1){1'b1}}};
    localparam logic signed [CSUM_W-1:0] C_MIN =
        {{(CSUM_W - C_W + 1){1'b1}}, {(C_W - 1){1'b0}}};

    typedef struct packed {
        logic [MW-1:0] a0;
        logic [MW-1:0] b0;
        logic [MW-1:0] a1;
        logic [MW-1:0] b1;
        logic [MW-1:0] a2;
        logic [MW-1:0] b2;
    } mul_ops_t;

    typedef struct packed {
        logic [PW-1:0] p0;
        logic [PW-1:0] p1;
        logic [PW-1:0] p2;
    } mul_prods_t;

endpackage

// ----- src/mandelbrot_escape_time_pixel.sv -----
// Top level: escape-time pixel engine with config registers and output register.
//
// Usage: an input beat on s_tvalid/s_tready carries one pixel coordinate pair.
// The block maps it to c = origin + coordinate * coord_step (saturated Q4.28)
// and iterates z = z*z + c until |z|^2 exceeds 4.0, z leaves +/-2.0 or max_iterations is hit.
// The output beat on m_tvalid/m_tready returns the coordinates and the count
// as an 8-bit grey level.
// Each iteration runs the three shared multipliers (zr*zr, zi*zi, zr*zi) in
// ST_MUL and then the add, escape and bound logic in ST_ADD.
// A max_iterations of zero skips the iterations and returns a grey level of zero.
// One pixel is in flight at a time, so s_tready is high only while the engine
// is idle, which it is again from the cycle after the previous result is stored.
// A finished result waits in the output register; if the receiver stalls
// with an earlier result still held, the engine waits before storing the new one.
// The configuration channel is always ready and should only be written while
// no pixel is in flight. Indexes above 3 are ignored.
// Reset restores origin -2.0 + -2.0i, step 4/640 and a limit of 255, and
// empties the engine and the output register.
module mandelbrot_escape_time_pixel
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [met_pkg::IN_TDATA_W-1:0]     s_tdata,   // pixel_x, pixel_y, zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [met_pkg::OUT_TDATA_W-1:0]    m_tdata,   // out_x, out_y, gray_level, zero pad
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [met_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [met_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMUL,
        ST_CADD,
        ST_ADD,
        ST_MUL,
        ST_FIN
    } state_t;

    localparam int CB = met_pkg::COORD_BITS;
    localparam int ZW = met_pkg::ZW;
    localparam int MW = met_pkg::MW;

    state_t state_reg, state_next;
    logic   first_reg, first_next;
    logic   out_valid_reg, out_valid_next;

    logic [met_pkg::C_W-1:0]    real_origin_reg;
    logic [met_pkg::C_W-1:0]    imag_origin_reg;
    logic [met_pkg::STEP_W-1:0] coord_step_reg;
    logic [met_pkg::ITER_W-1:0] max_iter_reg;

    logic [CB-1:0]               px_reg, px_next;
    logic [CB-1:0]               py_reg, py_next;
    logic [met_pkg::C_W-1:0]     cr_reg, cr_next;
    logic [met_pkg::C_W-1:0]     ci_reg, ci_next;
    logic [met_pkg::ITER_W-1:0]  count_reg, count_next;
    logic [MW-1:0]               mag_r_reg, mag_r_next;
    logic [MW-1:0]               mag_i_reg, mag_i_next;
    logic                        neg_reg, neg_next;
    logic [CB-1:0]               out_x_reg, out_x_next;
    logic [CB-1:0]               out_y_reg, out_y_next;
    logic [met_pkg::ITER_W-1:0]  gray_reg, gray_next;

    met_pkg::mul_ops_t   mul_ops;
    met_pkg::mul_prods_t mul_prods;
    logic                mul_en;

    logic signed [met_pkg::CSUM_W-1:0] cr_sum, ci_sum;
    logic [met_pkg::C_W-1:0]           cr_sat, ci_sat;

    logic [met_pkg::SQW-1:0] sqr, sqi;
    logic [met_pkg::SQW:0]   sq_sum;
    logic                    sq_esc;
    logic [met_pkg::CRW-1:0] cross_mag;
    logic signed [ZW-1:0]    cr_ext, ci_ext, cross_s;
    logic signed [ZW-1:0]    nzr, nzi, nzr_abs, nzi_abs;
    logic                    bound_esc;
    logic [met_pkg::ITER_W-1:0] count_inc;

    logic in_beat;
    logic out_load;

    assign in_beat   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

    // Multiplier operands: coordinate times step while mapping, zero to clear
    // the products before the first iteration, and the magnitudes of z after.
    always_comb
    begin
        mul_ops = '0;
        mul_en  = 1'b0;
        case (state_reg)
            ST_CMUL:
            begin
                mul_en     = 1'b1;
                mul_ops.a0 = MW'(px_reg);
                mul_ops.b0 = MW'(coord_step_reg);
                mul_ops.a1 = MW'(py_reg);
                mul_ops.b1 = MW'(coord_step_reg);
            end
            ST_CADD:
            begin
                mul_en = 1'b1;
            end
            ST_MUL:
            begin
                mul_en     = 1'b1;
                mul_ops.a0 = mag_r_reg;
                mul_ops.b0 = mag_r_reg;
                mul_ops.a1 = mag_i_reg;
                mul_ops.b1 = mag_i_reg;
                mul_ops.a2 = mag_r_reg;
                mul_ops.b2 = mag_i_reg;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    met_mul3 u_mul3
    (
        .clk   (clk),
        .en    (mul_en),
        .ops   (mul_ops),
        .prods (mul_prods)
    );

    // Mapping of pixel to c with saturation to the signed 32-bit range.
    always_comb
    begin
        cr_sum = met_pkg::CSUM_W'($signed(real_origin_reg))
               + $signed(met_pkg::CSUM_W'(mul_prods.p0));
        ci_sum = met_pkg::CSUM_W'($signed(imag_origin_reg))
               + $signed(met_pkg::CSUM_W'(mul_prods.p1));
        if (cr_sum > met_pkg::C_MAX)
            cr_sat = met_pkg::C_MAX[met_pkg::C_W-1:0];
        else if (cr_sum < met_pkg::C_MIN)
            cr_sat = met_pkg::C_MIN[met_pkg::C_W-1:0];
        else
            cr_sat = cr_sum[met_pkg::C_W-1:0];
        if (ci_sum > met_pkg::C_MAX)
            ci_sat = met_pkg::C_MAX[met_pkg::C_W-1:0];
        else if (ci_sum < met_pkg::C_MIN)
            ci_sat = met_pkg::C_MIN[met_pkg::C_W-1:0];
        else
            ci_sat = ci_sum[met_pkg::C_W-1:0];
    end

    // One iteration step: escape test on the previous squares and the new z.
    always_comb
    begin
        sqr       = met_pkg::SQW'(mul_prods.p0 >> met_pkg::FRAC_BITS);
        sqi       = met_pkg::SQW'(mul_prods.p1 >> met_pkg::FRAC_BITS);
        cross_mag = met_pkg::CRW'(mul_prods.p2 >> (met_pkg::FRAC_BITS - 1));
        sq_sum    = {1'b0, sqr} + {1'b0, sqi};
        sq_esc    = (sq_sum > met_pkg::SQ_FOUR);
        cr_ext    = {{(ZW - met_pkg::C_W){cr_reg[met_pkg::C_W-1]}}, cr_reg};
        ci_ext    = {{(ZW - met_pkg::C_W){ci_reg[met_pkg::C_W-1]}}, ci_reg};
        cross_s   = neg_reg ? -$signed(ZW'(cross_mag)) : $signed(ZW'(cross_mag));
        nzr       = $signed(ZW'(sqr)) - $signed(ZW'(sqi)) + cr_ext;
        nzi       = cross_s + ci_ext;
        nzr_abs   = nzr[ZW-1] ? -nzr : nzr;
        nzi_abs   = nzi[ZW-1] ? -nzi : nzi;
        bound_esc = (nzr > met_pkg::Z_TWO) || (nzr < met_pkg::Z_NEG_TWO) ||
                    (nzi > met_pkg::Z_TWO) || (nzi < met_pkg::Z_NEG_TWO);
        count_inc = count_reg + 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        count_next     = count_reg;
        mag_r_next     = mag_r_reg;
        mag_i_next     = mag_i_reg;
        neg_next       = neg_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        gray_next      = gray_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    px_next    = s_tdata[CB-1:0];
                    py_next    = s_tdata[2*CB-1:CB];
                    state_next = ST_CMUL;
                end
            end
            ST_CMUL:
            begin
                state_next = ST_CADD;
            end
            ST_CADD:
            begin
                cr_next    = cr_sat;
                ci_next    = ci_sat;
                count_next = '0;
                neg_next   = 1'b0;
                first_next = 1'b1;
                if (max_iter_reg == '0)
                    state_next = ST_FIN;
                else
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (!first_reg && sq_esc)
                begin
                    state_next = ST_FIN;
                end
                else if (!first_reg && (count_inc == max_iter_reg))
                begin
                    count_next = count_inc;
                    state_next = ST_FIN;
                end
                else
                begin
                    if (!first_reg)
                        count_next = count_inc;
                    first_next = 1'b0;
                    if (bound_esc)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        mag_r_next = MW'(nzr_abs);
                        mag_i_next = MW'(nzi_abs);
                        neg_next   = nzr[ZW-1] ^ nzi[ZW-1];
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    out_x_next     = px_reg;
                    out_y_next     = py_reg;
                    gray_next      = count_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            first_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            real_origin_reg <= met_pkg::RST_REAL_ORIGIN;
            imag_origin_reg <= met_pkg::RST_IMAG_ORIGIN;
            coord_step_reg  <= met_pkg::RST_COORD_STEP;
            max_iter_reg    <= met_pkg::RST_MAX_ITER;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    met_pkg::REG_REAL_ORIGIN:
                        real_origin_reg <= cfg_data[met_pkg::C_W-1:0];
                    met_pkg::REG_IMAG_ORIGIN:
                        imag_origin_reg <= cfg_data[met_pkg::C_W-1:0];
                    met_pkg::REG_COORD_STEP:
                        coord_step_reg <= cfg_data[met_pkg::STEP_W-1:0];
                    met_pkg::REG_MAX_ITER:
                        max_iter_reg <= cfg_data[met_pkg::ITER_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        count_reg <= count_next;
        mag_r_reg <= mag_r_next;
        mag_i_reg <= mag_i_next;
        neg_reg   <= neg_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        gray_reg  <= gray_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = met_pkg::OUT_TDATA_W'({gray_reg, out_y_reg, out_x_reg});

endmodule

// ----- src/met_mul3.sv -----
// Three registered unsigned multipliers shared by coordinate mapping and iteration.
module met_mul3
(
    input  logic                clk,
    input  logic                en,
    input  met_pkg::mul_ops_t   ops,
    output met_pkg::mul_prods_t prods
);

    met_pkg::mul_prods_t prods_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prods_reg.p0 <= ops.a0 * ops.b0;
            prods_reg.p1 <= ops.a1 * ops.b1;
            prods_reg.p2 <= ops.a2 * ops.b2;
        end
    end

    assign prods = prods_reg;

endmodule
